@@ hdl/fenwick_range_sum_point_add_assert.svh @@
// ----------------------------------------------------------------------------
// Fenwick range sum assertion macros
// Shorthand for the concurrent checks used in the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef FENWICK_RANGE_SUM_POINT_ADD_ASSERT_SVH
`define FENWICK_RANGE_SUM_POINT_ADD_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FRSPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FRSPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ hdl/frspa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum package
// Field widths, command and read codes, and the controller/datapath structs.
// ----------------------------------------------------------------------------
package frspa_pkg;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 64;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUM = 1'b1;

   // Kind of a tree walk step and of the memory read it issues.
   localparam logic [1:0] RD_ADD   = 2'd0;
   localparam logic [1:0] RD_PLUS  = 2'd1;
   localparam logic [1:0] RD_MINUS = 2'd2;

   typedef struct packed {
      logic       clear_en;
      logic       load_req;
      logic       walk_en;
      logic [1:0] walk_kind;
      logic       load_lo;
      logic       respond;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_active;
      logic is_sum;
      logic first_ok;
      logic last_ok;
   } dp_status_type;

endpackage

@@ hdl/frspa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum controller
// Sequences the clearing pass, the tree walks and the response strobe.
// ----------------------------------------------------------------------------
`include "fenwick_range_sum_point_add_assert.svh"

module frspa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  frspa_pkg::dp_status_type status,
   output frspa_pkg::dp_cmd_type    cmd
);
   import frspa_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_ADD    = 3'd3;
   localparam logic [2:0] S_SUM_HI = 3'd4;
   localparam logic [2:0] S_SUM_LO = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.is_sum) begin
               state_in = status.first_ok ? S_ADD : S_IDLE;
            end else if (status.first_ok && status.last_ok) begin
               state_in = S_SUM_HI;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ADD: begin
            cmd.walk_en   = 1'b1;
            cmd.walk_kind = RD_ADD;
            if (!status.walk_active) begin
               state_in = S_IDLE;
            end
         end
         S_SUM_HI: begin
            if (status.walk_active) begin
               cmd.walk_en   = 1'b1;
               cmd.walk_kind = RD_PLUS;
            end else begin
               cmd.load_lo = 1'b1;
               state_in    = S_SUM_LO;
            end
         end
         S_SUM_LO: begin
            if (status.walk_active) begin
               cmd.walk_en   = 1'b1;
               cmd.walk_kind = RD_MINUS;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `FRSPA_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !cmd.respond && !cmd.walk_en)
   `FRSPA_ASSERT_NEXT(a_accept_decode, clock, reset, start && !busy, state_ff == S_DECODE)
   `FRSPA_ASSERT_NEXT(a_respond_idle, clock, reset, cmd.respond, state_ff == S_IDLE)

endmodule

@@ hdl/frspa_datapath.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum datapath
// Cell memory, walking index, accumulator and the registered response.
// ----------------------------------------------------------------------------
`include "fenwick_range_sum_point_add_assert.svh"

module frspa_datapath #(
   parameter int NUM_POSITIONS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frspa_pkg::dp_cmd_type               cmd,
   output frspa_pkg::dp_status_type            status,
   input  logic                                req_command,
   input  logic [frspa_pkg::IDX_W-1:0]         req_first_index,
   input  logic [frspa_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [frspa_pkg::DATA_W-1:0] req_delta,
   output logic                                rsp_valid,
   output logic signed [frspa_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                                rsp_bad_index
);
   import frspa_pkg::*;

   localparam int PosBase = ($clog2(NUM_POSITIONS + 1) > IDX_W) ?
                            $clog2(NUM_POSITIONS + 1) : IDX_W;
   // One spare bit so that a climb past the last cell is still seen.
   localparam int PosW    = PosBase + 1;
   localparam int AddrW   = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;

   localparam logic [PosW-1:0]  NumPos   = PosW'(NUM_POSITIONS);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(NUM_POSITIONS - 1);

   logic [DATA_W-1:0] mem [NUM_POSITIONS];

   logic              cmd_ff;
   logic [IDX_W-1:0]  first_ff;
   logic [IDX_W-1:0]  last_ff;
   logic [DATA_W-1:0] delta_ff;
   logic [PosW-1:0]   idx_ff, idx_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rd_valid_ff;
   logic [1:0]        rd_kind_ff;
   logic [AddrW-1:0]  rd_addr_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [AddrW-1:0]  clr_cnt_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_sum_ff;
   logic              rsp_bad_ff;

   logic [PosW-1:0]   first_ext, last_ext, low_bit, idx_m1;
   logic [AddrW-1:0]  rd_addr_in;
   logic              rd_issue;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign first_ext  = {{(PosW-IDX_W){1'b0}}, first_ff};
   assign last_ext   = {{(PosW-IDX_W){1'b0}}, last_ff};
   assign low_bit    = idx_ff & (~idx_ff + PosW'(1));
   assign idx_m1     = idx_ff - PosW'(1);
   assign rd_addr_in = idx_m1[AddrW-1:0];

   assign status.clear_done  = (clr_cnt_ff == LastAddr);
   assign status.walk_active = (idx_ff != '0) && (idx_ff <= NumPos);
   assign status.is_sum      = (cmd_ff == CMD_SUM);
   assign status.first_ok    = (first_ext != '0) && (first_ext <= NumPos);
   assign status.last_ok     = (last_ext != '0) && (last_ext <= NumPos);

   assign rd_issue = cmd.walk_en && status.walk_active;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = (req_command == CMD_SUM) ? {{(PosW-IDX_W){1'b0}}, req_last_index}
                                           : {{(PosW-IDX_W){1'b0}}, req_first_index};
      end else if (cmd.load_lo) begin
         idx_in = first_ext - PosW'(1);
      end else if (rd_issue) begin
         idx_in = (cmd.walk_kind == RD_ADD) ? idx_ff + low_bit : idx_ff - low_bit;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_req) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         case (rd_kind_ff)
            RD_PLUS:  acc_in = acc_ff + rd_data_ff;
            RD_MINUS: acc_in = acc_ff - rd_data_ff;
            default:  acc_in = acc_ff;
         endcase
      end
   end

   // The clearing pass and add write-backs never overlap.
   assign wr_en   = cmd.clear_en || (rd_valid_ff && (rd_kind_ff == RD_ADD));
   assign wr_addr = cmd.clear_en ? clr_cnt_ff : rd_addr_ff;
   assign wr_data = cmd.clear_en ? '0 : rd_data_ff + delta_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_issue;
         rsp_valid_ff <= cmd.respond;
         if (cmd.clear_en) begin
            clr_cnt_ff <= clr_cnt_ff + AddrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      rd_kind_ff <= cmd.walk_kind;
      rd_addr_ff <= rd_addr_in;
      if (cmd.load_req) begin
         cmd_ff   <= req_command;
         first_ff <= req_first_index;
         last_ff  <= req_last_index;
         delta_ff <= req_delta;
      end
      if (cmd.respond) begin
         rsp_bad_ff <= !(status.first_ok && status.last_ok);
         rsp_sum_ff <= (status.first_ok && status.last_ok) ? acc_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_bad_index = rsp_bad_ff;

   `FRSPA_ASSERT_IMP(a_no_wr_clash, clock, reset, cmd.clear_en, !(rd_valid_ff && rd_kind_ff == RD_ADD))
   `FRSPA_ASSERT_IMP(a_rd_addr_range, clock, reset, rd_valid_ff, rd_addr_ff <= LastAddr)
   `FRSPA_ASSERT_NEXT(a_acc_cleared, clock, reset, cmd.load_req, acc_ff == '0)

endmodule

@@ hdl/fenwick_range_sum_point_add.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum with point add
// Binary indexed tree of signed 64-bit cells with point add and range sum.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low. An
// add request (command 0) adds delta at first_index and returns nothing; a
// sum request (command 1) returns the wrapped sum of positions first_index to
// last_index, or bad_index with a zero sum when either index is 0 or above
// NUM_POSITIONS. An add with a bad index is dropped silently. The response is
// shown for a single cycle with rsp_valid high and cannot be held off, so the
// receiver must take it on that cycle. All cells live in one memory with one
// read and one write port, and the tree walk touches one cell per cycle.
// Busy stays high until the block is through with the request in hand, so a
// new request waits for the last one. An add walks the cells on its upward
// path (at most about log2(NUM_POSITIONS) + 1 cells), and a sum walks the
// cells on both downward prefix paths (at most about 2 * log2(NUM_POSITIONS)
// cells). A query with a bad index, like an add with a bad index, walks no
// cells. After reset the block writes zero to every cell, with busy held
// high, before the first request is taken.
// ----------------------------------------------------------------------------
module fenwick_range_sum_point_add #(
   parameter int NUM_POSITIONS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [frspa_pkg::IDX_W-1:0]         req_first_index,
   input  logic [frspa_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [frspa_pkg::DATA_W-1:0] req_delta,
   output logic                                rsp_valid,
   output logic signed [frspa_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                                rsp_bad_index
);
   import frspa_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller owns the sequence; the datapath owns the cells and sums.
   frspa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (dp_cmd)
   );

   frspa_datapath #(
      .NUM_POSITIONS (NUM_POSITIONS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_command     (req_command),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_delta       (req_delta),
      .rsp_valid       (rsp_valid),
      .rsp_range_sum   (rsp_range_sum),
      .rsp_bad_index   (rsp_bad_index)
   );

endmodule

@@ dv/fenwick_sum_checker.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum checker
// Predicts the range sum for each accepted request and compares the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fenwick_sum_checker #(
   parameter int NUM_POSITIONS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_command,
   input  logic [frspa_pkg::IDX_W-1:0]         req_first_index,
   input  logic [frspa_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [frspa_pkg::DATA_W-1:0] req_delta,
   input  logic                                rsp_valid,
   input  logic signed [frspa_pkg::DATA_W-1:0] rsp_range_sum,
   input  logic                                rsp_bad_index,
   output int                                  mismatch_count,
   output int                                  sums_outstanding
);
   import frspa_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] total;
      logic              bad;
   } sum_result_type;

   // Plain per-position values; the tree form is the design's business.
   logic [DATA_W-1:0] position_value [1:NUM_POSITIONS];
   sum_result_type    expected_sums [$];
   int                mismatches  = 0;
   int                outstanding = 0;

   assign mismatch_count   = mismatches;
   assign sums_outstanding = outstanding;

   function automatic logic index_ok(input logic [IDX_W-1:0] idx);
      return (idx != 0) && (idx <= NUM_POSITIONS);
   endfunction

   // Wrapped sum of positions 1..upto.
   function automatic logic [DATA_W-1:0] running_total(input int upto);
      logic [DATA_W-1:0] acc;
      acc = '0;
      for (int p = 1; p <= upto; p++)
         acc += position_value[p];
      return acc;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: range sum check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      sum_result_type oldest;
      sum_result_type fresh;
      if (reset) begin
         foreach (position_value[p])
            position_value[p] = '0;
         expected_sums.delete();
      end else begin
         // The response is handled before any new request at this edge.
         if (rsp_valid === 1'b1) begin
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("unexpected response, sum %0d bad_index %b",
                                         rsp_range_sum, rsp_bad_index));
            end else begin
               oldest = expected_sums.pop_front();
               if (rsp_bad_index !== oldest.bad)
                  report_mismatch($sformatf("bad_index %b, expected %b",
                                            rsp_bad_index, oldest.bad));
               if (rsp_range_sum !== oldest.total)
                  report_mismatch($sformatf("range_sum %0d, expected %0d",
                                            rsp_range_sum, $signed(oldest.total)));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid is unknown");
         end

         if (start === 1'b1 && busy !== 1'b0 && busy !== 1'b1)
            report_mismatch("busy is unknown while a request is offered");

         if (start === 1'b1 && busy === 1'b0) begin
            if (req_command == CMD_ADD) begin
               if (index_ok(req_first_index))
                  position_value[req_first_index] += req_delta;
            end else begin
               if (!index_ok(req_first_index) || !index_ok(req_last_index)) begin
                  fresh.total = '0;
                  fresh.bad   = 1'b1;
               end else begin
                  // A reversed range falls out of the same prefix difference.
                  fresh.total = running_total(int'(req_last_index))
                              - running_total(int'(req_first_index) - 1);
                  fresh.bad   = 1'b0;
               end
               expected_sums.insert(expected_sums.size(), fresh);
            end
         end
      end
      outstanding = expected_sums.size();
   end

endmodule

@@ dv/tb_fenwick_range_sum_point_add.sv @@
// ----------------------------------------------------------------------------
// Fenwick range sum testbench
// Drives add and sum requests with random idling; a checker judges responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fenwick_range_sum_point_add;

   localparam int NUM_POSITIONS = 1024;
   localparam int RANDOM_ITEMS  = 1000;
   // Beyond this many counted random requests the sender stops idling.
   localparam int CALM_FROM     = 850;

   localparam logic [frspa_pkg::DATA_W-1:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [frspa_pkg::DATA_W-1:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [frspa_pkg::DATA_W-1:0] MINUS_ONE     = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_command;
   logic [frspa_pkg::IDX_W-1:0]         req_first_index;
   logic [frspa_pkg::IDX_W-1:0]         req_last_index;
   logic signed [frspa_pkg::DATA_W-1:0] req_delta;
   logic                                rsp_valid;
   logic signed [frspa_pkg::DATA_W-1:0] rsp_range_sum;
   logic                                rsp_bad_index;
   int                                  mismatch_count;
   int                                  sums_outstanding;

   // Whether the sender may leave gaps between requests.
   bit idling_on;

   fenwick_range_sum_point_add #(
      .NUM_POSITIONS(NUM_POSITIONS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_first_index(req_first_index),
      .req_last_index (req_last_index),
      .req_delta      (req_delta),
      .rsp_valid      (rsp_valid),
      .rsp_range_sum  (rsp_range_sum),
      .rsp_bad_index  (rsp_bad_index)
   );

   // The checker sees exactly what crosses the ports and keeps its own copy of
   // the stored values, so the stimulus side needs no knowledge of the sums.
   fenwick_sum_checker #(
      .NUM_POSITIONS(NUM_POSITIONS)
   ) sum_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_delta       (req_delta),
      .rsp_valid       (rsp_valid),
      .rsp_range_sum   (rsp_range_sum),
      .rsp_bad_index   (rsp_bad_index),
      .mismatch_count  (mismatch_count),
      .sums_outstanding(sums_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous ceiling: the clearing pass plus every request at its longest
   // walk and longest gap comes to well under a tenth of this.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Offers one request and holds it until the block takes it. Before the
   // request a random idle gap may be left, so that gaps
   // land on every phase of the previous walk. Inputs move only on the falling
   // edge; acceptance is judged on the rising edge, where busy still shows its
   // value from the cycle that edge ends.
   task automatic issue_request(input logic                         command,
                                input logic [frspa_pkg::IDX_W-1:0]  first_index,
                                input logic [frspa_pkg::IDX_W-1:0]  last_index,
                                input logic [frspa_pkg::DATA_W-1:0] delta);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_command     <= command;
      req_first_index <= first_index;
      req_last_index  <= last_index;
      req_delta       <= delta;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Mostly valid positions, with a cluster near the low end so that adds and
   // sums overlap often, plus the edges, powers of two and out-of-range values
   // up to the top of the 11-bit field.
   function automatic logic [frspa_pkg::IDX_W-1:0] pick_index();
      case ($urandom_range(0, 39))
         0:       return '0;
         1:       return frspa_pkg::IDX_W'(NUM_POSITIONS + $urandom_range(1, 1023));
         2, 3:    return frspa_pkg::IDX_W'(1 << $urandom_range(0, 10));
         4:       return frspa_pkg::IDX_W'(NUM_POSITIONS);
         5:       return frspa_pkg::IDX_W'(1);
         6, 7, 8, 9, 10, 11:
                  return frspa_pkg::IDX_W'($urandom_range(1, 16));
         default: return frspa_pkg::IDX_W'($urandom_range(1, NUM_POSITIONS));
      endcase
   endfunction

   // Full-width random deltas, small signed ones and the extremes, so that
   // sums both stay readable and wrap around.
   function automatic logic [frspa_pkg::DATA_W-1:0] pick_delta();
      int modest;
      modest = int'($urandom_range(0, 2000)) - 1000;
      case ($urandom_range(0, 9))
         0:       return MOST_POSITIVE;
         1:       return MOST_NEGATIVE;
         2:       return MINUS_ONE;
         3, 4, 5: return {{32{modest[31]}}, modest};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int                          counted;
      logic                        command;
      logic [frspa_pkg::IDX_W-1:0] first_index;
      logic [frspa_pkg::IDX_W-1:0] last_index;
      logic [frspa_pkg::IDX_W-1:0] swap_index;

      start           = 1'b0;
      req_command     = frspa_pkg::CMD_ADD;
      req_first_index = '0;
      req_last_index  = '0;
      req_delta       = '0;
      reset           = 1'b1;
      idling_on       = 1'b1;
      counted         = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its store after reset with busy held
      // high, so the first request simply waits for that pass to finish.
      issue_request(frspa_pkg::CMD_SUM, 11'd1, 11'd1024, '0);   // empty store
      issue_request(frspa_pkg::CMD_ADD, 11'd1, 11'd0, MOST_POSITIVE);
      issue_request(frspa_pkg::CMD_ADD, 11'd1024, 11'd1024, MOST_NEGATIVE);
      issue_request(frspa_pkg::CMD_ADD, 11'd512, 11'd3, MINUS_ONE);
      // Adds at a bad position must leave the store untouched.
      issue_request(frspa_pkg::CMD_ADD, 11'd0, 11'd5, 64'h1234);
      issue_request(frspa_pkg::CMD_ADD, 11'd1025, 11'd1, MINUS_ONE);
      issue_request(frspa_pkg::CMD_ADD, 11'd2047, 11'd2047, MOST_POSITIVE);
      issue_request(frspa_pkg::CMD_SUM, 11'd1, 11'd1024, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd1, 11'd1, MINUS_ONE);
      issue_request(frspa_pkg::CMD_SUM, 11'd1024, 11'd1024, '0);
      // Two large positive values at adjacent positions wrap the sum.
      issue_request(frspa_pkg::CMD_ADD, 11'd2, 11'd0, MOST_POSITIVE);
      issue_request(frspa_pkg::CMD_SUM, 11'd1, 11'd2, '0);
      // Sums with a bad bound give a flagged zero.
      issue_request(frspa_pkg::CMD_SUM, 11'd0, 11'd5, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd5, 11'd0, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd1025, 11'd3, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd3, 11'd2047, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd2047, 11'd2047, MINUS_ONE);
      issue_request(frspa_pkg::CMD_ADD, 11'd300, 11'd0, 64'h5555_5555_5555_5555);
      issue_request(frspa_pkg::CMD_ADD, 11'd700, 11'd0, 64'hAAAA_AAAA_AAAA_AAAA);
      // Reversed ranges, including the one that must come out as zero.
      issue_request(frspa_pkg::CMD_SUM, 11'd700, 11'd300, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd513, 11'd512, '0);
      issue_request(frspa_pkg::CMD_ADD, 11'd1023, 11'd1023, 64'd42);
      issue_request(frspa_pkg::CMD_SUM, 11'd1023, 11'd1024, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd1, 11'd1023, '0);
      issue_request(frspa_pkg::CMD_SUM, 11'd1024, 11'd1, '0);

      // Random part. Adds and sums come in about equal measure; most ranges
      // run upwards, the rest are reversed. Adds at a bad position are still
      // sent but do not count, since the block merely drops them.
      while (counted < RANDOM_ITEMS) begin
         idling_on   = (counted < CALM_FROM);
         command     = ($urandom_range(0, 1) == 0) ? frspa_pkg::CMD_ADD
                                                   : frspa_pkg::CMD_SUM;
         first_index = pick_index();
         last_index  = pick_index();
         if (command == frspa_pkg::CMD_SUM && first_index > last_index &&
             $urandom_range(0, 2) != 0) begin
            swap_index  = first_index;
            first_index = last_index;
            last_index  = swap_index;
         end
         issue_request(command, first_index, last_index, pick_delta());
         if (command == frspa_pkg::CMD_SUM ||
             (first_index != 0 && first_index <= NUM_POSITIONS))
            counted++;
      end

      @(negedge clock);
      start <= 1'b0;

      // Drain: wait for every outstanding sum, then allow a full walk more so
      // that any stray response would still be caught.
      while (sums_outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatch_count == 0 && sums_outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
